// File: rtl/core/oracle_equal_range_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the equal-range search core
// Clocked on clk, disabled while rst_n is low; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ORACLE_EQUAL_RANGE_SEARCH_CORE_ASSERT_SVH
`define ORACLE_EQUAL_RANGE_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OERS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oers assertion failed");

// next-cycle implication
`define OERS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oers assertion failed");

`else

`define OERS_ASSERT_IMP(name, ante, cons)
`define OERS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: rtl/core/oers_pkg.sv
// ----------------------------------------------------------------------------
// oers_pkg
// Constants, types and the microcode program of the equal-range search core.
// ----------------------------------------------------------------------------
package oers_pkg;

    // Sizes
    localparam int MAX_N       = 1024;
    localparam int N_W         = $clog2(MAX_N + 1);
    localparam int E_W         = N_W + 1;
    localparam int MEMO_DEPTH  = MAX_N + 1;
    localparam int MEMO_W      = 3;          // {known, reply[1:0]}
    localparam logic [N_W-1:0] MEMO_LAST = N_W'(MAX_N);

    // n/3 as a multiply by a rounded-up reciprocal, exact for n < 2**N_W
    localparam int THIRD_SHIFT = N_W + 1;
    localparam int THIRD_MUL   = ((1 << THIRD_SHIFT) + 2) / 3;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    // Reply codes as stored in the memo
    localparam logic [1:0] REPLY_ZERO = 2'b00;
    localparam logic [1:0] REPLY_POS  = 2'b01;

    // Search phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    // Microprogram steps
    typedef enum logic [3:0] {
        UPC_WAIT,
        UPC_CLR,
        UPC_PICK,
        UPC_LOOK,
        UPC_PROBE,
        UPC_END,
        UPC_FPLK,
        UPC_DONE
    } upc_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_CLEAR,
        MEM_RD_MID,
        MEM_RD_FIRST
    } mem_op_t;

    typedef enum logic [1:0] {
        APPLY_NONE,
        APPLY_MEMO,
        APPLY_FIRST
    } apply_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_PROBE,
        OUT_FINAL
    } out_sel_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_CLR_LAST,
        COND_EMPTY,
        COND_MEMO_HIT,
        COND_PHASE_SECOND,
        COND_OUT_FREE
    } cond_t;

    // One control word
    typedef struct packed {
        logic     in_rdy;
        mem_op_t  mem_op;
        apply_t   apply;
        logic     next_phase;
        out_sel_t out_sel;
        cond_t    cond;
        upc_t     jump_to;
        upc_t     next_to;
    } ctrl_t;

    // Control store
    function automatic ctrl_t ucode_rom(input upc_t upc);
        ctrl_t w;
        w = '{in_rdy: 1'b0, mem_op: MEM_NONE, apply: APPLY_NONE, next_phase: 1'b0,
              out_sel: OUT_NONE, cond: COND_ALWAYS, jump_to: UPC_WAIT, next_to: UPC_WAIT};
        unique case (upc)
            UPC_WAIT:
            begin
                w.in_rdy  = 1'b1;
                w.cond    = COND_DISPATCH;
                w.jump_to = UPC_PICK;
                w.next_to = UPC_WAIT;
            end
            UPC_CLR:
            begin
                w.mem_op  = MEM_CLEAR;
                w.cond    = COND_CLR_LAST;
                w.jump_to = UPC_PROBE;
                w.next_to = UPC_CLR;
            end
            UPC_PICK:
            begin
                w.mem_op  = MEM_RD_MID;
                w.cond    = COND_EMPTY;
                w.jump_to = UPC_END;
                w.next_to = UPC_LOOK;
            end
            UPC_LOOK:
            begin
                w.apply   = APPLY_MEMO;
                w.cond    = COND_MEMO_HIT;
                w.jump_to = UPC_PICK;
                w.next_to = UPC_PROBE;
            end
            UPC_PROBE:
            begin
                w.out_sel = OUT_PROBE;
                w.cond    = COND_OUT_FREE;
                w.jump_to = UPC_WAIT;
                w.next_to = UPC_PROBE;
            end
            UPC_END:
            begin
                w.mem_op     = MEM_RD_FIRST;
                w.next_phase = 1'b1;
                w.cond       = COND_PHASE_SECOND;
                w.jump_to    = UPC_DONE;
                w.next_to    = UPC_FPLK;
            end
            UPC_FPLK:
            begin
                w.apply   = APPLY_FIRST;
                w.cond    = COND_ALWAYS;
                w.jump_to = UPC_PICK;
                w.next_to = UPC_PICK;
            end
            UPC_DONE:
            begin
                w.out_sel = OUT_FINAL;
                w.cond    = COND_OUT_FREE;
                w.jump_to = UPC_WAIT;
                w.next_to = UPC_DONE;
            end
            default:
            begin
                w.cond    = COND_ALWAYS;
                w.jump_to = UPC_WAIT;
                w.next_to = UPC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/oers_ram.sv
// ----------------------------------------------------------------------------
// oers_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oers_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/oracle_equal_range_search_core.sv
// ----------------------------------------------------------------------------
// oracle_equal_range_search_core
// Microcoded binary search for the run of positions where an oracle says 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, cmd, reply): cmd = 0 starts a search,
//   cmd = 1 carries the oracle's reply to the last probe. A reply while no
//   search runs is taken and dropped. in_stall is low only while the
//   sequencer waits for the next transaction.
//   Output channel (out_valid/out_stall): one transaction per start or search reply,
//   either a probe request (done_res = 0) or the final low_end/high_end pair.
//   size_n is written through cfg_we/cfg_data, latched at start; the user
//   must write it only while idle, as the core does not enforce that.
// Steps and back-pressure:
//   A start runs a clearing pass over the 1025-entry reply memo (one entry a
//   cycle) before its probe is emitted. A reply takes one memo read (PICK)
//   and one update (LOOK) per probe, repeated while the probe is found in
//   the memo; the switch to the high-end search adds a read (END) and an
//   update (FPLK) of the first probe. The output register holds a result
//   while out_stall is high; the next input transaction is still taken, and
//   the sequencer waits at the next emit step until the output register frees up.
// Reset: size 1024, no search running, output empty; memo contents undefined.
// ----------------------------------------------------------------------------
`include "oracle_equal_range_search_core_assert.svh"

module oracle_equal_range_search_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [oers_pkg::N_W-1:0]          cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic signed [1:0]                 reply,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              done_res,
    output logic [oers_pkg::N_W-1:0]          probe_index,
    output logic signed [oers_pkg::E_W-1:0]   low_end,
    output logic signed [oers_pkg::E_W-1:0]   high_end
);

    import oers_pkg::*;

    localparam logic [N_W-1:0] ONE_N   = N_W'(1);
    localparam logic [N_W-1:0] THREE_N = N_W'(3);
    localparam logic [N_W-1:0] MAX_NW  = N_W'(MAX_N);
    localparam logic signed [E_W-1:0] NONE_E = -E_W'(1);

    // sequencer
    upc_t  upc_reg, upc_next;
    ctrl_t ctl;

    // datapath registers
    logic [N_W-1:0]          size_n_reg, size_n_next;
    logic [N_W-1:0]          cur_n_reg, cur_n_next;
    logic [N_W-1:0]          third_reg, third_next;
    logic [N_W-1:0]          bound_lo_reg, bound_lo_next;
    logic [N_W-1:0]          bound_hi_reg, bound_hi_next;
    logic signed [E_W-1:0]   found_low_reg, found_low_next;
    logic signed [E_W-1:0]   found_high_reg, found_high_next;
    logic [N_W-1:0]          first_reg, first_next;
    logic [N_W-1:0]          pending_reg, pending_next;
    logic [N_W-1:0]          probe_reg, probe_next;
    logic [N_W-1:0]          clr_cnt_reg, clr_cnt_next;
    phase_t                  phase_reg, phase_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    done_res_reg, done_res_next;
    logic [N_W-1:0]          probe_index_reg, probe_index_next;
    logic signed [E_W-1:0]   low_end_reg, low_end_next;
    logic signed [E_W-1:0]   high_end_reg, high_end_next;

    // handshakes
    logic accept, start_acc, reply_acc, out_free, out_load;
    logic load_final, load_probe;

    // start-time probe
    logic [N_W-1:0]          eff_n;
    logic [2*N_W-1:0]        third_prod;
    logic [N_W-1:0]          third_start;
    logic [N_W:0]            half_sum_start;
    logic [N_W-1:0]          first_start;

    // probe selection
    logic                    full_span;
    logic [N_W:0]            bound_sum;
    logic [N_W-1:0]          mid;

    // memo
    logic                    mem_we;
    logic [N_W-1:0]          mem_waddr, mem_raddr;
    logic [MEMO_W-1:0]       mem_wdata, mem_rdata;
    logic                    memo_hit;

    // bound update
    logic                    apply_en, apply_second;
    logic [N_W-1:0]          apply_idx;
    logic [1:0]              apply_code;
    logic                    v_zero, v_pos, v_neg, dec_hi;

    // control word of the current step
    always_comb
    begin
        ctl = ucode_rom(upc_reg);
    end

    assign accept     = in_valid && ctl.in_rdy;
    assign start_acc  = accept && (cmd == CMD_START);
    assign reply_acc  = accept && (cmd == CMD_REPLY) && (phase_reg != PH_IDLE);
    assign in_stall   = !ctl.in_rdy;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = (ctl.out_sel != OUT_NONE) && out_free;
    assign load_final = out_load && (ctl.out_sel == OUT_FINAL);
    assign load_probe = out_load && (ctl.out_sel == OUT_PROBE);
    assign memo_hit   = mem_rdata[MEMO_W-1];

    // step sequencing
    always_comb
    begin
        upc_next = ctl.next_to;
        unique case (ctl.cond)
            COND_ALWAYS:       upc_next = ctl.jump_to;
            COND_DISPATCH:
            begin
                if (start_acc)
                    upc_next = UPC_CLR;
                else if (reply_acc)
                    upc_next = ctl.jump_to;
            end
            COND_CLR_LAST:     if (clr_cnt_reg == MEMO_LAST) upc_next = ctl.jump_to;
            COND_EMPTY:        if (bound_lo_reg > bound_hi_reg) upc_next = ctl.jump_to;
            COND_MEMO_HIT:     if (memo_hit) upc_next = ctl.jump_to;
            COND_PHASE_SECOND: if (phase_reg == PH_SECOND) upc_next = ctl.jump_to;
            COND_OUT_FREE:     if (out_free) upc_next = ctl.jump_to;
            default:           upc_next = UPC_WAIT;
        endcase
    end

    // size clamp and first probe at start: n/3 by reciprocal multiply (midpoint for n < 3)
    always_comb
    begin
        if (size_n_reg == '0)
            eff_n = ONE_N;
        else if (size_n_reg > MAX_NW)
            eff_n = MAX_NW;
        else
            eff_n = size_n_reg;
        third_prod     = (2*N_W)'(eff_n) * (2*N_W)'(THIRD_MUL);
        third_start    = N_W'(third_prod >> THIRD_SHIFT);
        half_sum_start = ({1'b0, eff_n} + (N_W+1)'(1)) >> 1;
        first_start    = (eff_n >= THREE_N) ? third_start : half_sum_start[N_W-1:0];
    end

    // probe for the current bounds
    always_comb
    begin
        full_span = (bound_lo_reg == ONE_N) && (bound_hi_reg == cur_n_reg)
                    && (cur_n_reg >= THREE_N);
        bound_sum = {1'b0, bound_lo_reg} + {1'b0, bound_hi_reg};
        mid       = full_span ? third_reg : bound_sum[N_W:1];
    end

    // memo ports
    always_comb
    begin
        if (ctl.mem_op == MEM_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = reply_acc;
            mem_waddr = pending_reg;
            mem_wdata = {1'b1, $unsigned(reply)};
        end
        mem_raddr = (ctl.mem_op == MEM_RD_FIRST) ? first_reg : mid;
    end

    oers_ram #(
        .WIDTH (MEMO_W),
        .DEPTH (MEMO_DEPTH)
    ) u_memo (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // reply source for the bound update
    always_comb
    begin
        apply_en     = 1'b0;
        apply_second = (phase_reg == PH_SECOND);
        apply_idx    = pending_reg;
        apply_code   = $unsigned(reply);
        if (reply_acc)
        begin
            apply_en = 1'b1;
        end
        else if (ctl.apply == APPLY_MEMO)
        begin
            apply_en   = memo_hit;
            apply_idx  = probe_reg;
            apply_code = mem_rdata[1:0];
        end
        else if (ctl.apply == APPLY_FIRST)
        begin
            // first probe reused; an unknown entry counts as inside the run
            apply_en     = 1'b1;
            apply_second = 1'b1;
            apply_idx    = first_reg;
            apply_code   = memo_hit ? mem_rdata[1:0] : REPLY_ZERO;
        end
        v_zero = (apply_code == REPLY_ZERO);
        v_pos  = (apply_code == REPLY_POS);
        v_neg  = apply_code[1];
        dec_hi = apply_second ? v_pos : !v_neg;
    end

    // datapath next state
    always_comb
    begin
        size_n_next     = cfg_we ? cfg_data : size_n_reg;
        cur_n_next      = cur_n_reg;
        third_next      = third_reg;
        bound_lo_next   = bound_lo_reg;
        bound_hi_next   = bound_hi_reg;
        found_low_next  = found_low_reg;
        found_high_next = found_high_reg;
        first_next      = first_reg;
        pending_next    = pending_reg;
        probe_next      = probe_reg;
        clr_cnt_next    = clr_cnt_reg;
        phase_next      = phase_reg;

        if (start_acc)
        begin
            cur_n_next      = eff_n;
            third_next      = third_start;
            bound_lo_next   = ONE_N;
            bound_hi_next   = eff_n;
            found_low_next  = NONE_E;
            found_high_next = NONE_E;
            first_next      = first_start;
            pending_next    = first_start;
            clr_cnt_next    = '0;
            phase_next      = PH_FIRST;
        end

        if (ctl.mem_op == MEM_CLEAR)
            clr_cnt_next = clr_cnt_reg + ONE_N;
        if (ctl.mem_op == MEM_RD_MID)
            probe_next = mid;
        if ((ctl.apply == APPLY_MEMO) && !memo_hit)
            pending_next = probe_reg;

        // move one bound past the probe
        if (apply_en)
        begin
            if (v_zero && !apply_second)
                found_low_next = $signed({1'b0, apply_idx});
            if (v_zero && apply_second)
                found_high_next = $signed({1'b0, apply_idx});
            if (dec_hi)
                bound_hi_next = apply_idx - ONE_N;
            else
                bound_lo_next = apply_idx + ONE_N;
        end

        // low end settled: restart bounds for the high end
        if (ctl.next_phase && (phase_reg == PH_FIRST))
        begin
            phase_next    = PH_SECOND;
            bound_lo_next = ONE_N;
            bound_hi_next = cur_n_reg;
        end

        if (load_final)
            phase_next = PH_IDLE;
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        done_res_next    = done_res_reg;
        probe_index_next = probe_index_reg;
        low_end_next     = low_end_reg;
        high_end_next    = high_end_reg;
        if (load_final)
        begin
            out_valid_next   = 1'b1;
            done_res_next    = 1'b1;
            probe_index_next = '0;
            low_end_next     = found_low_reg;
            high_end_next    = found_high_reg;
        end
        else if (load_probe)
        begin
            out_valid_next   = 1'b1;
            done_res_next    = 1'b0;
            probe_index_next = pending_reg;
            low_end_next     = '0;
            high_end_next    = '0;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg         <= UPC_WAIT;
            size_n_reg      <= MAX_NW;
            cur_n_reg       <= MAX_NW;
            third_reg       <= '0;
            bound_lo_reg    <= ONE_N;
            bound_hi_reg    <= MAX_NW;
            found_low_reg   <= NONE_E;
            found_high_reg  <= NONE_E;
            first_reg       <= '0;
            pending_reg     <= '0;
            probe_reg       <= '0;
            clr_cnt_reg     <= '0;
            phase_reg       <= PH_IDLE;
            out_valid_reg   <= 1'b0;
            done_res_reg    <= 1'b0;
            probe_index_reg <= '0;
            low_end_reg     <= '0;
            high_end_reg    <= '0;
        end
        else
        begin
            upc_reg         <= upc_next;
            size_n_reg      <= size_n_next;
            cur_n_reg       <= cur_n_next;
            third_reg       <= third_next;
            bound_lo_reg    <= bound_lo_next;
            bound_hi_reg    <= bound_hi_next;
            found_low_reg   <= found_low_next;
            found_high_reg  <= found_high_next;
            first_reg       <= first_next;
            pending_reg     <= pending_next;
            probe_reg       <= probe_next;
            clr_cnt_reg     <= clr_cnt_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
            done_res_reg    <= done_res_next;
            probe_index_reg <= probe_index_next;
            low_end_reg     <= low_end_next;
            high_end_reg    <= high_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign done_res    = done_res_reg;
    assign probe_index = probe_index_reg;
    assign low_end     = low_end_reg;
    assign high_end    = high_end_reg;

    // checks
    `OERS_ASSERT_NXT(a_final_ends_search, load_final, (phase_reg == PH_IDLE) && done_res)
    `OERS_ASSERT_NXT(a_probe_in_range, load_probe, (probe_index != '0) && (probe_index <= cur_n_reg))
    `OERS_ASSERT_IMP(a_memo_lookup_active, upc_reg == UPC_LOOK, phase_reg != PH_IDLE)

endmodule

// File: tb/sv/oracle_equal_range_search_core_tb.sv
// ----------------------------------------------------------------------------
// oracle_equal_range_search_core_tb
// Self-checking bench for the equal-range search core. A stimulus process
// acts as the oracle: it picks a hidden run of zero positions, steps its own
// model of the search to learn each probe, and queues the matching replies
// together with the results the core must produce. A clocked driver feeds the
// queued transactions and a clocked monitor checks every output transaction.
// Random idling on both sides and long output hold-offs exercise the
// back-pressure paths.
// ----------------------------------------------------------------------------
module oracle_equal_range_search_core_tb;

    import oers_pkg::*;

    // Negative reply encodings (both mean "probe is below the run")
    localparam logic [1:0] REPLY_NEG     = 2'b11;
    localparam logic [1:0] REPLY_NEG_ALT = 2'b10;

    localparam int IDLE_PCT     = 17;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int STUCK_LIMIT  = 4000;
    localparam int ITEM_TARGET  = 1000;
    localparam int NO_CAP       = 100000;
    localparam int PRINT_CAP    = 30;

    typedef struct {
        logic       cmd;
        logic [1:0] reply;
    } txn_t;

    typedef struct {
        logic                    done;
        logic [N_W-1:0]          probe;
        logic signed [E_W-1:0]   lo_end;
        logic signed [E_W-1:0]   hi_end;
    } search_res_t;

    // DUT signals
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [N_W-1:0]         cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   cmd = CMD_START;
    logic signed [1:0]      reply = REPLY_ZERO;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   done_res;
    logic [N_W-1:0]         probe_index;
    logic signed [E_W-1:0]  low_end;
    logic signed [E_W-1:0]  high_end;

    // Pending input transactions and expected output transactions
    txn_t        pend_items[$];
    search_res_t exp_results[$];

    // Search model state
    logic [N_W-1:0] size_reg;
    bit             memo_known [0:MAX_N];
    int             memo_val   [0:MAX_N];
    int             lo_b, hi_b, low_pos, high_pos, first_pos, pend_pos, cur_n;
    phase_t         phase;

    // Bookkeeping
    int n_errors = 0;
    int n_checked = 0;
    int n_results_gen = 0;
    int n_ignored = 0;
    int n_searches = 0;
    int n_sizes = 0;
    int n_holds = 0;
    int n_in_acc = 0;
    int n_out_acc = 0;
    int n_out_seen = 0;
    int next_hold = 60;
    int hold_left = 0;
    int stuck_cycles = 0;
    txn_t drv_item;

    oracle_equal_range_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .reply       (reply),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .done_res    (done_res),
        .probe_index (probe_index),
        .low_end     (low_end),
        .high_end    (high_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Search model
    // ------------------------------------------------------------------------
    function automatic int clamp_size(input logic [N_W-1:0] raw);
        if (raw < 1)
            return 1;
        if (raw > MAX_N)
            return MAX_N;
        return int'(raw);
    endfunction

    // n/3 while the bounds span the full range and n >= 3, midpoint otherwise
    function automatic int pick_pos(input int lo, input int hi);
        if (lo == 1 && hi == cur_n && cur_n >= 3)
            return cur_n / 3;
        return (lo + hi) / 2;
    endfunction

    function automatic void narrow_low(input int v, input int pos);
        if (v == 0)
        begin
            low_pos = pos;
            hi_b = pos - 1;
        end
        else if (v > 0)
            hi_b = pos - 1;
        else
            lo_b = pos + 1;
    endfunction

    function automatic void narrow_high(input int v, input int pos);
        if (v == 0)
        begin
            high_pos = pos;
            lo_b = pos + 1;
        end
        else if (v < 0)
            lo_b = pos + 1;
        else
            hi_b = pos - 1;
    endfunction

    // Run through memo hits until a new probe is needed or the search ends
    function automatic search_res_t walk_search();
        search_res_t res;
        int mid;
        bit fin;
        fin = 1'b0;
        while (!fin)
        begin
            if (lo_b <= hi_b)
            begin
                mid = pick_pos(lo_b, hi_b);
                if (!memo_known[mid])
                begin
                    pend_pos = mid;
                    res.done = 1'b0;
                    res.probe = N_W'(mid);
                    res.lo_end = '0;
                    res.hi_end = '0;
                    fin = 1'b1;
                end
                else if (phase == PH_FIRST)
                    narrow_low(memo_val[mid], mid);
                else
                    narrow_high(memo_val[mid], mid);
            end
            else if (phase == PH_FIRST)
            begin
                // high-end search reuses the first probe's reply
                phase = PH_SECOND;
                lo_b = 1;
                hi_b = cur_n;
                narrow_high(memo_known[first_pos] ? memo_val[first_pos] : 0, first_pos);
            end
            else
            begin
                phase = PH_IDLE;
                res.done = 1'b1;
                res.probe = '0;
                res.lo_end = E_W'(low_pos);
                res.hi_end = E_W'(high_pos);
                fin = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic bit search_step(input logic c, input logic [1:0] r,
                                       output search_res_t res);
        int v;
        int i;
        if (c == CMD_START)
        begin
            for (i = 0; i <= MAX_N; i++)
                memo_known[i] = 1'b0;
            cur_n = clamp_size(size_reg);
            lo_b = 1;
            hi_b = cur_n;
            low_pos = -1;
            high_pos = -1;
            first_pos = pick_pos(1, cur_n);
            pend_pos = first_pos;
            phase = PH_FIRST;
            res.done = 1'b0;
            res.probe = N_W'(first_pos);
            res.lo_end = '0;
            res.hi_end = '0;
            return 1'b1;
        end
        if (phase == PH_IDLE)
            return 1'b0;
        v = (r == REPLY_ZERO) ? 0 : (r == REPLY_POS) ? 1 : -1;
        memo_known[pend_pos] = 1'b1;
        memo_val[pend_pos] = v;
        if (phase == PH_FIRST)
            narrow_low(v, pend_pos);
        else
            narrow_high(v, pend_pos);
        res = walk_search();
        return 1'b1;
    endfunction

    // Oracle with a hidden zero run za..zb (empty when za > zb)
    function automatic logic [1:0] oracle_reply(input int p, input int za, input int zb);
        if (p < za)
            return ($urandom_range(1) != 0) ? REPLY_NEG : REPLY_NEG_ALT;
        if (p > zb)
            return REPLY_POS;
        return REPLY_ZERO;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic log_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic push_item(input logic c, input logic [1:0] r,
                             output bit got, output search_res_t res);
        txn_t t;
        t.cmd = c;
        t.reply = r;
        pend_items.push_back(t);
        got = search_step(c, r, res);
        if (got)
        begin
            exp_results.push_back(res);
            n_results_gen++;
        end
        else
            n_ignored++;
    endtask

    // One search against the hidden run, cut short after max_replies replies
    task automatic queue_search(input int za, input int zb, input int max_replies,
                                input int noise_pct);
        search_res_t res;
        bit got;
        int replies;
        logic [1:0] r;
        replies = 0;
        n_searches++;
        r = 2'($urandom_range(3));
        push_item(CMD_START, r, got, res);
        while (got && !res.done && replies < max_replies)
        begin
            if ($urandom_range(99) < noise_pct)
                r = 2'($urandom_range(3));
            else
                r = oracle_reply(res.probe, za, zb);
            push_item(CMD_REPLY, r, got, res);
            replies++;
        end
        // stray replies once no search runs
        if (got && res.done && $urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 2))
            begin
                r = 2'($urandom_range(3));
                push_item(CMD_REPLY, r, got, res);
            end
        end
    endtask

    // Wait until every transaction has gone through and the core is quiet
    task automatic settle();
        @(negedge clk);
        while (pend_items.size() != 0 || in_valid || exp_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(input logic [N_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg = v;
        n_sizes++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                n_in_acc++;
            if (!in_valid || !in_stall)
            begin
                if (pend_items.size() != 0 &&
                    ((n_in_acc >= CALM_FROM && n_in_acc < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    drv_item = pend_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= drv_item.cmd;
                    reply <= drv_item.reply;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall: random idling plus long hold-offs
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                n_out_seen++;
            if (hold_left == 0 && n_out_seen >= next_hold)
            begin
                hold_left = HOLD_CYCLES;
                next_hold += 500;
                n_holds++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (n_out_seen >= CALM_FROM && n_out_seen < CALM_TO)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_out_acc++;
            if (exp_results.size() == 0)
                log_mismatch($sformatf("result %0d arrived with nothing expected", n_out_acc));
            else
            begin
                search_res_t want;
                want = exp_results.pop_front();
                n_checked++;
                if (done_res !== want.done)
                    log_mismatch($sformatf("result %0d done_res got %0b want %0b",
                                           n_out_acc, done_res, want.done));
                if (probe_index !== want.probe)
                    log_mismatch($sformatf("result %0d probe_index got %0d want %0d",
                                           n_out_acc, probe_index, want.probe));
                if (low_end !== want.lo_end)
                    log_mismatch($sformatf("result %0d low_end got %0d want %0d",
                                           n_out_acc, low_end, want.lo_end));
                if (high_end !== want.hi_end)
                    log_mismatch($sformatf("result %0d high_end got %0d want %0d",
                                           n_out_acc, high_end, want.hi_end));
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        search_res_t res;
        bit got;
        int first_rand;
        int sel;
        int n;
        int za;
        int zb;
        int cap;
        int noise;
        logic [N_W-1:0] sz;

        size_reg = N_W'(MAX_N);
        phase = PH_IDLE;
        cur_n = MAX_N;
        lo_b = 1;
        hi_b = MAX_N;
        low_pos = -1;
        high_pos = -1;
        first_pos = 0;
        pend_pos = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: replies with no search running
        push_item(CMD_REPLY, REPLY_ZERO, got, res);
        push_item(CMD_REPLY, REPLY_NEG_ALT, got, res);
        // reset size; restart while a search is still running
        queue_search(1, MAX_N, 3, 0);
        queue_search(700, 705, 2, 0);
        // size 0 acts as 1
        settle();
        write_size('0);
        queue_search(1, 1, NO_CAP, 0);
        // size 2: no zero anywhere, every probe above
        settle();
        write_size(N_W'(2));
        queue_search(1, 0, NO_CAP, 0);
        // size 3: smallest size using the n/3 probe
        settle();
        write_size(N_W'(3));
        queue_search(3, 3, NO_CAP, 0);
        // sizes above the maximum clamp to it
        settle();
        write_size(N_W'(MAX_N + 1));
        queue_search(MAX_N, MAX_N, 4, 0);
        settle();
        write_size('1);
        queue_search(1, MAX_N, 2, 100);

        // Random phases: one size each, a few searches per phase
        first_rand = n_results_gen;
        while (n_results_gen - first_rand < ITEM_TARGET)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                case ($urandom_range(6))
                    0: sz = '0;
                    1: sz = N_W'(1);
                    2: sz = N_W'(2);
                    3: sz = N_W'(3);
                    4: sz = N_W'(MAX_N);
                    5: sz = N_W'(MAX_N + 1);
                    default: sz = '1;
                endcase
            else if (sel < 70)
                sz = N_W'($urandom_range(1, 40));
            else if (sel < 90)
                sz = N_W'($urandom_range(41, 300));
            else
                sz = N_W'($urandom_range(301, 2047));
            settle();
            write_size(sz);
            n = clamp_size(sz);
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(99) < 70)
                begin
                    za = $urandom_range(1, n);
                    if ($urandom_range(1) != 0)
                        zb = za + $urandom_range(0, 3);
                    else
                        zb = za + $urandom_range(0, n);
                    if (zb > n)
                        zb = n;
                end
                else
                begin
                    // empty run: split point between below and above
                    zb = $urandom_range(0, n);
                    za = zb + 1;
                end
                cap = ($urandom_range(99) < 10) ? $urandom_range(0, 6) : NO_CAP;
                noise = ($urandom_range(99) < 10) ? 15 : 0;
                queue_search(za, zb, cap, noise);
            end
        end

        settle();
        $display("Ran %0d searches over %0d size writes, sizes 0..2047 incl. clamped ones;",
                 n_searches, n_sizes);
        $display("checked %0d results, %0d replies sent with no search, %0d long hold-offs.",
                 n_checked, n_ignored, n_holds);
        if (n_errors == 0 && exp_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
